/* hdl/sbx_pkg.sv */
// Package for the swept box versus box hit-time block.
// Holds widths, time constants and the structs shared across modules.
`timescale 1ns / 1ps
package sbx_pkg;

   localparam int COORD_W    = 32;
   localparam int HALF_W     = 31;
   localparam int EDGE_W     = 33;
   localparam int GAP_W      = 34;
   localparam int MAG_W      = 33;
   localparam int QI_W       = 18;
   localparam int TIME_W     = 17;
   localparam int DIV_STAGES = 6;
   localparam int DIV_STEPS  = 3;
   localparam int NSTAGE     = 11;

   localparam logic [TIME_W-1:0] T_ONE = 17'd65536;
   localparam logic [TIME_W-1:0] T_SAT = 17'd65537;

   typedef struct packed {
      logic signed [COORD_W-1:0] mover_center_x;
      logic signed [COORD_W-1:0] mover_center_y;
      logic [HALF_W-1:0]         mover_half_x;
      logic [HALF_W-1:0]         mover_half_y;
      logic signed [COORD_W-1:0] mover_vel_x;
      logic signed [COORD_W-1:0] mover_vel_y;
      logic signed [COORD_W-1:0] other_center_x;
      logic signed [COORD_W-1:0] other_center_y;
      logic [HALF_W-1:0]         other_half_x;
      logic [HALF_W-1:0]         other_half_y;
      logic signed [COORD_W-1:0] other_vel_x;
      logic signed [COORD_W-1:0] other_vel_y;
   } req_type;

   typedef struct packed {
      logic miss;
      logic use_en;
      logic use_ex;
   } axis_flag_type;

   typedef struct packed {
      axis_flag_type             fx;
      axis_flag_type             fy;
      logic signed [COORD_W-1:0] mcx;
      logic signed [COORD_W-1:0] mcy;
      logic signed [COORD_W-1:0] mvx;
      logic signed [COORD_W-1:0] mvy;
   } ctx_type;

endpackage

/* hdl/sbx_if.sv */
// Request and response channel interfaces for the hit-time block.
// Depends on sbx_pkg for widths.
`timescale 1ns / 1ps
interface sbx_req_if;
   import sbx_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] mover_center_x;
   logic signed [COORD_W-1:0] mover_center_y;
   logic [HALF_W-1:0]         mover_half_x;
   logic [HALF_W-1:0]         mover_half_y;
   logic signed [COORD_W-1:0] mover_vel_x;
   logic signed [COORD_W-1:0] mover_vel_y;
   logic signed [COORD_W-1:0] other_center_x;
   logic signed [COORD_W-1:0] other_center_y;
   logic [HALF_W-1:0]         other_half_x;
   logic [HALF_W-1:0]         other_half_y;
   logic signed [COORD_W-1:0] other_vel_x;
   logic signed [COORD_W-1:0] other_vel_y;

   modport source (output valid, mover_center_x, mover_center_y, mover_half_x, mover_half_y,
                   mover_vel_x, mover_vel_y, other_center_x, other_center_y, other_half_x,
                   other_half_y, other_vel_x, other_vel_y, input ready);
   modport sink (input valid, mover_center_x, mover_center_y, mover_half_x, mover_half_y,
                 mover_vel_x, mover_vel_y, other_center_x, other_center_y, other_half_x,
                 other_half_y, other_vel_x, other_vel_y, output ready);
endinterface

interface sbx_rsp_if;
   import sbx_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [TIME_W-1:0]         entry_time;
   logic signed [COORD_W-1:0] contact_x;
   logic signed [COORD_W-1:0] contact_y;

   modport source (output valid, hit, entry_time, contact_x, contact_y, input ready);
   modport sink (input valid, hit, entry_time, contact_x, contact_y, output ready);
endinterface

/* hdl/sbx_setup.sv */
// Front two stages: box edges and relative velocity, then slab gaps and flags.
// Depends on sbx_pkg.
`timescale 1ns / 1ps
module sbx_setup (
   input  logic                 clock,
   input  logic [1:0]           en,
   input  sbx_pkg::req_type     req,
   output sbx_pkg::ctx_type     ctx,
   output logic [33:0]          gap_en_x,
   output logic [33:0]          gap_ex_x,
   output logic [32:0]          mag_x,
   output logic [33:0]          gap_en_y,
   output logic [33:0]          gap_ex_y,
   output logic [32:0]          mag_y
);
   import sbx_pkg::*;

   typedef struct packed {
      logic signed [EDGE_W-1:0] bmin;
      logic signed [EDGE_W-1:0] bmax;
      logic signed [EDGE_W-1:0] amin;
      logic signed [EDGE_W-1:0] amax;
      logic signed [EDGE_W-1:0] v;
   } edge_type;

   typedef struct packed {
      axis_flag_type     f;
      logic [GAP_W-1:0]  gen;
      logic [GAP_W-1:0]  gex;
      logic [MAG_W-1:0]  mag;
   } slab_type;

   function automatic edge_type mk_edges(logic signed [COORD_W-1:0] bc,
                                         logic [HALF_W-1:0] bh,
                                         logic signed [COORD_W-1:0] ac,
                                         logic [HALF_W-1:0] ah,
                                         logic signed [COORD_W-1:0] bv,
                                         logic signed [COORD_W-1:0] av);
      edge_type e;
      e.bmin = $signed({bc[COORD_W-1], bc}) - $signed({2'b00, bh});
      e.bmax = $signed({bc[COORD_W-1], bc}) + $signed({2'b00, bh});
      e.amin = $signed({ac[COORD_W-1], ac}) - $signed({2'b00, ah});
      e.amax = $signed({ac[COORD_W-1], ac}) + $signed({2'b00, ah});
      e.v    = $signed({bv[COORD_W-1], bv}) - $signed({av[COORD_W-1], av});
      return e;
   endfunction

   function automatic logic [GAP_W-1:0] diff(logic signed [EDGE_W-1:0] x,
                                             logic signed [EDGE_W-1:0] y);
      logic signed [GAP_W-1:0] d;
      d = $signed({x[EDGE_W-1], x}) - $signed({y[EDGE_W-1], y});
      return d;
   endfunction

   function automatic slab_type mk_slab(edge_type e);
      slab_type s;
      logic [EDGE_W-1:0] nv;
      s.f   = '0;
      s.gen = '0;
      s.gex = '0;
      nv    = -e.v;
      s.mag = e.v[EDGE_W-1] ? nv : e.v;
      if (e.v == '0) begin
         s.f.miss = (e.bmax < e.amin) || (e.bmin > e.amax);
      end else if (e.v[EDGE_W-1]) begin
         s.f.miss   = e.bmax < e.amin;
         s.f.use_en = e.amax < e.bmin;
         s.gen      = diff(e.bmin, e.amax);
         s.f.use_ex = e.bmax > e.amin;
         s.gex      = diff(e.bmax, e.amin);
      end else begin
         s.f.miss   = e.bmin > e.amax;
         s.f.use_en = e.bmax < e.amin;
         s.gen      = diff(e.amin, e.bmax);
         s.f.use_ex = e.amax > e.bmin;
         s.gex      = diff(e.amax, e.bmin);
      end
      return s;
   endfunction

   edge_type ex_ff, ey_ff, ex_in, ey_in;
   ctx_type  ca_ff, ca_in, cb_ff, cb_in;
   slab_type sx_ff, sy_ff, sx_in, sy_in;

   always_comb begin
      ex_in     = mk_edges(req.mover_center_x, req.mover_half_x, req.other_center_x,
                           req.other_half_x, req.mover_vel_x, req.other_vel_x);
      ey_in     = mk_edges(req.mover_center_y, req.mover_half_y, req.other_center_y,
                           req.other_half_y, req.mover_vel_y, req.other_vel_y);
      ca_in     = '0;
      ca_in.mcx = req.mover_center_x;
      ca_in.mcy = req.mover_center_y;
      ca_in.mvx = req.mover_vel_x;
      ca_in.mvy = req.mover_vel_y;
      sx_in     = mk_slab(ex_ff);
      sy_in     = mk_slab(ey_ff);
      cb_in     = ca_ff;
      cb_in.fx  = sx_in.f;
      cb_in.fy  = sy_in.f;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         ca_ff <= ca_in;
      end
      if (en[1]) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         cb_ff <= cb_in;
      end
   end

   assign ctx      = cb_ff;
   assign gap_en_x = sx_ff.gen;
   assign gap_ex_x = sx_ff.gex;
   assign mag_x    = sx_ff.mag;
   assign gap_en_y = sy_ff.gen;
   assign gap_ex_y = sy_ff.gex;
   assign mag_y    = sy_ff.mag;

endmodule

/* hdl/sbx_div.sv */
// Pipelined restoring divider: gap * 65536 / mag, saturated to 65537.
// Six stages of three quotient bits each. Depends on sbx_pkg.
`timescale 1ns / 1ps
module sbx_div (
   input  logic                                 clock,
   input  logic [sbx_pkg::DIV_STAGES-1:0]       en,
   input  logic [sbx_pkg::GAP_W-1:0]            gap,
   input  logic [sbx_pkg::MAG_W-1:0]            mag,
   output logic [sbx_pkg::TIME_W-1:0]           quot
);
   import sbx_pkg::*;

   logic [MAG_W-1:0] r_ff   [DIV_STAGES];
   logic [MAG_W-1:0] r_in   [DIV_STAGES];
   logic [MAG_W-1:0] m_ff   [DIV_STAGES];
   logic [MAG_W-1:0] m_in   [DIV_STAGES];
   logic [QI_W-1:0]  q_ff   [DIV_STAGES];
   logic [QI_W-1:0]  q_in   [DIV_STAGES];
   logic [1:0]       low_ff [DIV_STAGES];
   logic [1:0]       low_in [DIV_STAGES];
   logic             sat_ff [DIV_STAGES];
   logic             sat_in [DIV_STAGES];

   always_comb begin
      logic [MAG_W-1:0] pr;
      logic [MAG_W:0]   t;
      logic             b;
      int               i;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            pr        = {1'b0, gap[GAP_W-1:2]};
            m_in[s]   = mag;
            q_in[s]   = '0;
            low_in[s] = gap[1:0];
            sat_in[s] = {1'b0, gap} >= {mag, 2'b00};
         end else begin
            pr        = r_ff[s-1];
            m_in[s]   = m_ff[s-1];
            q_in[s]   = q_ff[s-1];
            low_in[s] = low_ff[s-1];
            sat_in[s] = sat_ff[s-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            i = QI_W - 1 - DIV_STEPS * s - k;
            b = (i == QI_W - 1) ? low_in[s][1] : ((i == QI_W - 2) ? low_in[s][0] : 1'b0);
            t = {pr, b};
            if (t >= {1'b0, m_in[s]}) begin
               t          = t - {1'b0, m_in[s]};
               q_in[s][i] = 1'b1;
            end
            pr = t[MAG_W-1:0];
         end
         r_in[s] = pr;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[s]) begin
            r_ff[s]   <= r_in[s];
            m_ff[s]   <= m_in[s];
            q_ff[s]   <= q_in[s];
            low_ff[s] <= low_in[s];
            sat_ff[s] <= sat_in[s];
         end
      end
   end

   assign quot = (sat_ff[DIV_STAGES-1] || (q_ff[DIV_STAGES-1] > {1'b0, T_SAT}))
                 ? T_SAT : q_ff[DIV_STAGES-1][TIME_W-1:0];

endmodule

/* hdl/sbx_contact.sv */
// Back three stages: interval merge and hit, velocity times time, contact point.
// Depends on sbx_pkg.
`timescale 1ns / 1ps
module sbx_contact (
   input  logic                              clock,
   input  logic [2:0]                        en,
   input  sbx_pkg::ctx_type                  ctx,
   input  logic [sbx_pkg::TIME_W-1:0]        q_en_x,
   input  logic [sbx_pkg::TIME_W-1:0]        q_ex_x,
   input  logic [sbx_pkg::TIME_W-1:0]        q_en_y,
   input  logic [sbx_pkg::TIME_W-1:0]        q_ex_y,
   output logic                              hit,
   output logic [sbx_pkg::TIME_W-1:0]        entry_time,
   output logic signed [sbx_pkg::COORD_W-1:0] contact_x,
   output logic signed [sbx_pkg::COORD_W-1:0] contact_y
);
   import sbx_pkg::*;

   localparam int PROD_W = COORD_W + TIME_W + 1;

   function automatic logic signed [COORD_W-1:0] place(logic signed [COORD_W-1:0] c,
                                                       logic signed [PROD_W-1:0] p);
      logic signed [COORD_W+2:0] sum;
      logic signed [COORD_W+2:0] hi;
      logic signed [COORD_W+2:0] lo;
      sum = $signed({{3{c[COORD_W-1]}}, c}) + $signed(p[PROD_W-1:16]);
      hi  = $signed({3'b000, 1'b0, {(COORD_W-1){1'b1}}});
      lo  = $signed({3'b111, 1'b1, {(COORD_W-1){1'b0}}});
      if (sum > hi) return hi[COORD_W-1:0];
      if (sum < lo) return lo[COORD_W-1:0];
      return sum[COORD_W-1:0];
   endfunction

   logic                       hit_c_ff, hit_c_in, hit_d_ff, hit_ff, hit_in;
   logic [TIME_W-1:0]          tf_c_ff, tf_c_in, tf_d_ff, tf_ff, tf_in, tl;
   logic signed [COORD_W-1:0]  mcx_c_ff, mcy_c_ff, mvx_c_ff, mvy_c_ff;
   logic signed [COORD_W-1:0]  mcx_d_ff, mcy_d_ff, cx_ff, cy_ff, cx_in, cy_in;
   logic signed [PROD_W-1:0]   px_ff, py_ff, px_in, py_in;

   always_comb begin
      tf_c_in = '0;
      tl      = T_ONE;
      if (ctx.fx.use_en && q_en_x > tf_c_in) tf_c_in = q_en_x;
      if (ctx.fy.use_en && q_en_y > tf_c_in) tf_c_in = q_en_y;
      if (ctx.fx.use_ex && q_ex_x < tl) tl = q_ex_x;
      if (ctx.fy.use_ex && q_ex_y < tl) tl = q_ex_y;
      hit_c_in = !ctx.fx.miss && !ctx.fy.miss && (tf_c_in <= tl);
   end

   assign px_in = mvx_c_ff * $signed({1'b0, tf_c_ff});
   assign py_in = mvy_c_ff * $signed({1'b0, tf_c_ff});

   assign hit_in = hit_d_ff;
   assign tf_in  = hit_d_ff ? tf_d_ff : '0;
   assign cx_in  = hit_d_ff ? place(mcx_d_ff, px_ff) : '0;
   assign cy_in  = hit_d_ff ? place(mcy_d_ff, py_ff) : '0;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hit_c_ff <= hit_c_in;
         tf_c_ff  <= tf_c_in;
         mcx_c_ff <= ctx.mcx;
         mcy_c_ff <= ctx.mcy;
         mvx_c_ff <= ctx.mvx;
         mvy_c_ff <= ctx.mvy;
      end
      if (en[1]) begin
         hit_d_ff <= hit_c_ff;
         tf_d_ff  <= tf_c_ff;
         mcx_d_ff <= mcx_c_ff;
         mcy_d_ff <= mcy_c_ff;
         px_ff    <= px_in;
         py_ff    <= py_in;
      end
      if (en[2]) begin
         hit_ff <= hit_in;
         tf_ff  <= tf_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
   end

   assign hit        = hit_ff;
   assign entry_time = tf_ff;
   assign contact_x  = cx_ff;
   assign contact_y  = cy_ff;

endmodule

/* hdl/swept_box_vs_box_hit_time.sv */
// Top level of the swept box versus box hit-time block.
// Depends on sbx_pkg, sbx_if, sbx_setup, sbx_div and sbx_contact.
//
//   channel   dir   ports     contents
//   req_bus   in    req_*     mover and other box: centre, half extent, motion
//   rsp_bus   out   rsp_*     hit, entry_time, contact_x, contact_y
//
// Eleven register stages: 2 setup, 6 divider (3 quotient bits each), 3 back end.
// One request per cycle while rsp_bus.ready does not hold the pipeline.
// Synchronous reset clears the stage valid bits only.
// Each stage holds only while it is full and the stage after it is blocked.
`timescale 1ns / 1ps
module swept_box_vs_box_hit_time (
   input logic         clock,
   input logic         reset,
   sbx_req_if.sink     req_bus,
   sbx_rsp_if.source   rsp_bus
);
   import sbx_pkg::*;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] en;
   req_type           req;
   ctx_type           ctx_b;
   ctx_type           ctx_ff [DIV_STAGES];
   logic [GAP_W-1:0]  gex, gxx, gey, gxy;
   logic [MAG_W-1:0]  mx, my;
   logic [TIME_W-1:0] qex, qxx, qey, qxy;

   always_comb begin
      en[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_bus.ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_bus.valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ctx_ff[0] <= ctx_b;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         if (en[2+s]) begin
            ctx_ff[s] <= ctx_ff[s-1];
         end
      end
   end

   assign req_bus.ready = en[0];
   assign rsp_bus.valid = valid_ff[NSTAGE-1];

   assign req.mover_center_x = req_bus.mover_center_x;
   assign req.mover_center_y = req_bus.mover_center_y;
   assign req.mover_half_x   = req_bus.mover_half_x;
   assign req.mover_half_y   = req_bus.mover_half_y;
   assign req.mover_vel_x    = req_bus.mover_vel_x;
   assign req.mover_vel_y    = req_bus.mover_vel_y;
   assign req.other_center_x = req_bus.other_center_x;
   assign req.other_center_y = req_bus.other_center_y;
   assign req.other_half_x   = req_bus.other_half_x;
   assign req.other_half_y   = req_bus.other_half_y;
   assign req.other_vel_x    = req_bus.other_vel_x;
   assign req.other_vel_y    = req_bus.other_vel_y;

   sbx_setup u_setup (
      .clock    (clock),
      .en       (en[1:0]),
      .req      (req),
      .ctx      (ctx_b),
      .gap_en_x (gex),
      .gap_ex_x (gxx),
      .mag_x    (mx),
      .gap_en_y (gey),
      .gap_ex_y (gxy),
      .mag_y    (my)
   );

   sbx_div u_div_enx (.clock(clock), .en(en[7:2]), .gap(gex), .mag(mx), .quot(qex));
   sbx_div u_div_exx (.clock(clock), .en(en[7:2]), .gap(gxx), .mag(mx), .quot(qxx));
   sbx_div u_div_eny (.clock(clock), .en(en[7:2]), .gap(gey), .mag(my), .quot(qey));
   sbx_div u_div_exy (.clock(clock), .en(en[7:2]), .gap(gxy), .mag(my), .quot(qxy));

   sbx_contact u_contact (
      .clock      (clock),
      .en         (en[10:8]),
      .ctx        (ctx_ff[DIV_STAGES-1]),
      .q_en_x     (qex),
      .q_ex_x     (qxx),
      .q_en_y     (qey),
      .q_ex_y     (qxy),
      .hit        (rsp_bus.hit),
      .entry_time (rsp_bus.entry_time),
      .contact_x  (rsp_bus.contact_x),
      .contact_y  (rsp_bus.contact_y)
   );

endmodule

/* hdl/sbx_checker.sv */
// Port-level checks for the hit-time block, bound to the top level.
// Depends on sbx_pkg for the time constant.
`timescale 1ns / 1ps
module sbx_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_hit,
   input logic [sbx_pkg::TIME_W-1:0]         rsp_entry_time,
   input logic signed [sbx_pkg::COORD_W-1:0] rsp_contact_x,
   input logic signed [sbx_pkg::COORD_W-1:0] rsp_contact_y
);
   import sbx_pkg::*;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_entry_time == '0 && rsp_contact_x == '0
                                && rsp_contact_y == '0)
      else $error("miss response carries nonzero fields");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_time <= T_ONE)
      else $error("entry time beyond one frame");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_time))
      else $error("stalled response changed");

endmodule

bind swept_box_vs_box_hit_time sbx_checker u_sbx_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hit        (rsp_bus.hit),
   .rsp_entry_time (rsp_bus.entry_time),
   .rsp_contact_x  (rsp_bus.contact_x),
   .rsp_contact_y  (rsp_bus.contact_y)
);

/* test/testbench.sv */
// Self-checking testbench for swept_box_vs_box_hit_time (2D swept box hit time).
// Depends on sbx_pkg, sbx_if and the block's RTL; drives req_bus, checks rsp_bus.
`timescale 1ns / 1ps
module testbench;
   import sbx_pkg::*;

   typedef struct packed {
      logic                      hit;
      logic [TIME_W-1:0]         entry_time;
      logic signed [COORD_W-1:0] contact_x;
      logic signed [COORD_W-1:0] contact_y;
   } hit_result_type;

   typedef struct {
      req_type        pair;
      bit             known;
      hit_result_type res;
   } stim_row_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_OFF = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   sbx_req_if req_bus ();
   sbx_rsp_if rsp_bus ();

   swept_box_vs_box_hit_time u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hit_result_type expected_hits[$];
   int  mismatch_count = 0;
   int  send_idle_pct = 19;
   int  recv_idle_pct = 70;
   bit  hold_recv = 1'b0;
   bit  stim_done = 1'b0;
   int  quiet_cycles = 0;

   // slab narrowing on one axis, times in Q1.16
   function automatic bit narrow_axis(longint bc, longint bh, longint ac, longint ah,
                                      longint v, inout longint tf, inout longint tl);
      longint bmin, bmax, amin, amax, t, mag;
      bmin = bc - bh; bmax = bc + bh;
      amin = ac - ah; amax = ac + ah;
      mag = (v < 0) ? -v : v;
      if (v == 0) begin
         if (bmax < amin || bmin > amax) return 1'b0;
      end else if (v < 0) begin
         if (bmax < amin) return 1'b0;
         if (amax < bmin) begin
            t = ((bmin - amax) * 65536) / mag;
            if (t > tf) tf = t;
         end
         if (bmax > amin) begin
            t = ((bmax - amin) * 65536) / mag;
            if (t < tl) tl = t;
         end
      end else begin
         if (bmin > amax) return 1'b0;
         if (bmax < amin) begin
            t = ((amin - bmax) * 65536) / mag;
            if (t > tf) tf = t;
         end
         if (amax > bmin) begin
            t = ((amax - bmin) * 65536) / mag;
            if (t < tl) tl = t;
         end
      end
      return tf <= tl;
   endfunction

   function automatic logic signed [31:0] move_center(longint c, longint vel, longint t);
      longint prod, r;
      prod = vel * t;
      r = c + (prod >>> 16);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic hit_result_type predict_hit(req_type p);
      hit_result_type r;
      longint tf, tl;
      bit h;
      tf = 0; tl = 65536;
      r = '0;
      h = narrow_axis(p.mover_center_x, p.mover_half_x, p.other_center_x, p.other_half_x,
                      longint'(p.mover_vel_x) - longint'(p.other_vel_x), tf, tl);
      if (h)
         h = narrow_axis(p.mover_center_y, p.mover_half_y, p.other_center_y, p.other_half_y,
                         longint'(p.mover_vel_y) - longint'(p.other_vel_y), tf, tl);
      if (h) begin
         r.hit = 1'b1;
         r.entry_time = tf[16:0];
         r.contact_x = move_center(p.mover_center_x, p.mover_vel_x, tf);
         r.contact_y = move_center(p.mover_center_y, p.mover_vel_y, tf);
      end
      return r;
   endfunction

   function automatic req_type make_pair(int cx, int cy, int hx, int hy, int vx, int vy,
                                         int ox, int oy, int ohx, int ohy, int ovx, int ovy);
      req_type p;
      p.mover_center_x = cx;      p.mover_center_y = cy;
      p.mover_half_x = hx[30:0];  p.mover_half_y = hy[30:0];
      p.mover_vel_x = vx;         p.mover_vel_y = vy;
      p.other_center_x = ox;      p.other_center_y = oy;
      p.other_half_x = ohx[30:0]; p.other_half_y = ohy[30:0];
      p.other_vel_x = ovx;        p.other_vel_y = ovy;
      return p;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // mostly plausible scenes: near boxes, moderate extents, frame-scale motion
   function automatic req_type rand_pair();
      req_type p;
      int span;
      logic [383:0] raw;
      if ($urandom_range(0, 9) < 2) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom};
         p = raw[$bits(req_type)-1:0];
         if ($urandom_range(0, 1)) begin
            p.mover_center_x = rand_word(); p.other_vel_y = rand_word();
            p.mover_half_x = 31'(rand_word()); p.other_half_y = 31'(rand_word());
         end
         return p;
      end
      span = 1 << $urandom_range(16, 24);
      p.mover_center_x = $urandom_range(0, span) - span / 2;
      p.mover_center_y = $urandom_range(0, span) - span / 2;
      p.other_center_x = $urandom_range(0, span) - span / 2;
      p.other_center_y = $urandom_range(0, span) - span / 2;
      p.mover_half_x = 31'($urandom_range(0, span / 4));
      p.mover_half_y = 31'($urandom_range(0, span / 4));
      p.other_half_x = 31'($urandom_range(0, span / 4));
      p.other_half_y = 31'($urandom_range(0, span / 4));
      p.mover_vel_x = $urandom_range(0, 2 * span) - span;
      p.mover_vel_y = $urandom_range(0, 2 * span) - span;
      p.other_vel_x = $urandom_range(0, 3) == 0 ? $urandom_range(0, span) - span / 2 : 0;
      p.other_vel_y = $urandom_range(0, 3) == 0 ? $urandom_range(0, span) - span / 2 : 0;
      if ($urandom_range(0, 5) == 0) p.mover_vel_x = p.other_vel_x;
      if ($urandom_range(0, 5) == 0) p.mover_vel_y = p.other_vel_y;
      return p;
   endfunction

   task automatic send_pair(req_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mover_center_x <= p.mover_center_x;
      req_bus.mover_center_y <= p.mover_center_y;
      req_bus.mover_half_x <= p.mover_half_x;
      req_bus.mover_half_y <= p.mover_half_y;
      req_bus.mover_vel_x <= p.mover_vel_x;
      req_bus.mover_vel_y <= p.mover_vel_y;
      req_bus.other_center_x <= p.other_center_x;
      req_bus.other_center_y <= p.other_center_y;
      req_bus.other_half_x <= p.other_half_x;
      req_bus.other_half_y <= p.other_half_y;
      req_bus.other_vel_x <= p.other_vel_x;
      req_bus.other_vel_y <= p.other_vel_y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      req_type p;
      int n;
      req_bus.valid <= 1'b0;
      {req_bus.mover_center_x, req_bus.mover_center_y, req_bus.mover_half_x,
       req_bus.mover_half_y, req_bus.mover_vel_x, req_bus.mover_vel_y} <= '0;
      {req_bus.other_center_x, req_bus.other_center_y, req_bus.other_half_x,
       req_bus.other_half_y, req_bus.other_vel_x, req_bus.other_vel_y} <= '0;

      // typed expectations: overlap, far miss, static touch, all-zero
      row.known = 1'b1;
      row.pair = make_pair(0, 0, 65536, 65536, 131072, 0, 65536, 0, 65536, 65536, 0, 0);
      row.res = '{1'b1, 17'd0, 32'sd0, 32'sd0};
      rows.push_back(row);
      row.pair = make_pair(0, 0, 65536, 65536, 0, 0, 1 << 24, 0, 65536, 65536, 0, 0);
      row.res = '0;
      rows.push_back(row);
      row.pair = make_pair(0, 0, 65536, 65536, 0, 0, 131072, 0, 65536, 65536, 0, 0);
      row.res = '{1'b1, 17'd0, 32'sd0, 32'sd0};
      rows.push_back(row);
      row.pair = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      row.res = '{1'b1, 17'd0, 32'sd0, 32'sd0};
      rows.push_back(row);
      // half-frame contact: gap 2.0 at speed 4.0
      row.pair = make_pair(0, 0, 65536, 65536, 262144, 0, 262144, 0, 65536, 65536, 0, 0);
      row.res = '{1'b1, 17'd32768, 32'sd131072, 32'sd0};
      rows.push_back(row);
      row.known = 1'b0;
      // contact at end of frame, moving other box, negative motion, y axis
      rows.push_back('{make_pair(0, 0, 65536, 65536, 131072, 0, 262144, 0, 65536, 65536,
                                 0, 0), 0, '0});
      rows.push_back('{make_pair(0, 0, 65536, 65536, 0, 0, 262144, 0, 65536, 65536,
                                 -196608, 0), 0, '0});
      rows.push_back('{make_pair(0, 0, 65536, 65536, 0, -200000, 0, -300000, 65536, 65536,
                                 0, 0), 0, '0});
      rows.push_back('{make_pair(0, 0, 65536, 65536, -100000, 0, 300000, 0, 65536, 65536,
                                 0, 0), 0, '0});
      rows.push_back('{make_pair(0, 0, 65536, 65536, 100000, 100000, 300000, 0, 65536,
                                 65536, 0, 0), 0, '0});
      // extremes and saturation
      rows.push_back('{make_pair(32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
                                 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                 31'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h7fffffff),
                       0, '0});
      rows.push_back('{make_pair(32'h80000000, 32'h80000000, 0, 0, 32'h80000000, 32'h80000000,
                                 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h7fffffff,
                                 32'h7fffffff), 0, '0});
      rows.push_back('{make_pair(32'h7fffffff, 32'h7fffffff, 0, 0, 32'h7fffffff,
                                 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0,
                                 32'h80000000, 32'h80000000), 0, '0});
      rows.push_back('{make_pair(32'h7fff0000, 0, 65536, 65536, 32'h7fffffff, 0,
                                 32'h7fffffff, 0, 31'h7fffffff, 65536, 0, 0), 0, '0});
      rows.push_back('{make_pair(-1, -1, 1, 1, -1, -1, 5, 5, 1, 1, 1, 1), 0, '0});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].known) expected_hits.push_back(rows[i].res);
         else expected_hits.push_back(predict_hit(rows[i].pair));
         send_pair(rows[i].pair);
      end
      for (n = 0; n < 1750; n++) begin
         if (n == 580) begin send_idle_pct = 70; recv_idle_pct = 19; end
         if (n == 1160) begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (n == 300) hold_recv = 1'b1;
         p = rand_pair();
         expected_hits.push_back(predict_hit(p));
         send_pair(p);
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (hold_recv) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
            hold_recv = 1'b0;
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      hit_result_type want, got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.hit, rsp_bus.entry_time, rsp_bus.contact_x, rsp_bus.contact_y};
         if (expected_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_hits.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (2 * NSTAGE + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_hits.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
